// ----- rtl/core/sfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types for the length-prefixed frame receiver: the parse phase and
// the result word that goes from the parser to the output register.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned ByteW = 8;

	// parse phase: identifier, length, payload, checksum
	typedef enum logic [1:0] {
		PH_IDENT   = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} phase_t;

	// one result word
	typedef struct packed {
		logic             payload_valid;
		logic [ByteW-1:0] payload_index;
		logic [ByteW-1:0] payload_byte;
		logic             frame_done;
		logic             frame_good;
		logic [ByteW-1:0] frame_ident;
		logic [ByteW-1:0] frame_length;
	} result_t;

endpackage : sfr_pkg
`default_nettype wire

// ----- rtl/core/sfr_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register for received bytes. Holds one word and passes it on when
// the downstream side has room; takes a new word in the same cycle.
// ----------------------------------------------------------------------------
module sfr_in_stage
	import sfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_stall,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire logic             out_free,
	output logic                  valid_s1,
	output logic [ByteW-1:0]      rx_byte_s1,
	output logic                  fire
);

	logic valid_q;
	logic [ByteW-1:0] data_q;

	// word leaves the register when the output side can take it
	assign fire       = valid_q && out_free;
	assign byte_stall = valid_q && !out_free;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!byte_stall) begin
			valid_q <= byte_valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_q <= rx_byte;
		end
	end

	assign valid_s1   = valid_q;
	assign rx_byte_s1 = data_q;

endmodule : sfr_in_stage
`default_nettype wire

// ----- rtl/core/sfr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parse state (phase, identifier, length, position, running sum) and
// the combinational result for the byte in the input register.
// ----------------------------------------------------------------------------
module sfr_parser
	import sfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [ByteW-1:0] rx_byte_s1,
	output result_t               res
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] ident_q, ident_d;
	logic [ByteW-1:0] length_q, length_d;
	logic [ByteW-1:0] pos_q, pos_d;
	logic [ByteW-1:0] sum_q, sum_d;
	logic [ByteW-1:0] pos_inc;

	assign pos_inc = pos_q + 8'd1;

	// state registers, updated only when a word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDENT;
			ident_q  <= '0;
			length_q <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			ident_q  <= ident_d;
			length_q <= length_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
		end
	end

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		ident_d  = ident_q;
		length_d = length_q;
		pos_d    = pos_q;
		sum_d    = sum_q;
		res      = '0;
		case (phase_q)
			PH_IDENT: begin
				ident_d = rx_byte_s1;
				sum_d   = rx_byte_s1;
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				length_d = rx_byte_s1;
				sum_d    = sum_q + rx_byte_s1;
				pos_d    = '0;
				phase_d  = (rx_byte_s1 == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_index = pos_q;
				res.payload_byte  = rx_byte_s1;
				sum_d             = sum_q + rx_byte_s1;
				pos_d             = pos_inc;
				if (pos_inc == length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res.frame_done = 1'b1;
				res.frame_good = (sum_q == rx_byte_s1);
				phase_d        = PH_IDENT;
			end
			default: begin
				phase_d = PH_IDENT;
			end
		endcase
		res.frame_ident  = ident_d;
		res.frame_length = length_d;
	end

	// checks
	a_ident_to_length: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_IDENT |=> phase_q == PH_LENGTH)
		else $error("identifier word did not lead to length phase");

	a_zero_length: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_LENGTH && rx_byte_s1 == '0 |=> phase_q == PH_CHECK)
		else $error("zero length did not skip to checksum");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pos_q < length_q)
		else $error("payload position beyond frame length");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(sum_q) && $stable(pos_q))
		else $error("parse state moved without a word");

endmodule : sfr_parser
`default_nettype wire

// ----- rtl/core/serial_frame_receiver_sum8_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum8_core
// Parses received bytes into frames (identifier, length, payload, checksum)
// with an 8-bit additive checksum; emits one result word per byte.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------
//   input    | byte_valid / byte_stall     | rx_byte
//   result   | result_valid / result_stall | payload_*, frame_*
//
// One byte per cycle sustained while the result side does not stall; a byte's
// result passes the input register, parser logic and output register.
// Parse state advances as a word moves from the input to the output register.
// Reset clears the parse state and both valid flags.
// A stalled result holds; the input register keeps taking words while the
// output register drains, and byte_stall rises only when both are full.
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum8_core
	import sfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_stall,
	input  wire logic [ByteW-1:0] rx_byte,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic                  payload_valid,
	output logic [ByteW-1:0]      payload_index,
	output logic [ByteW-1:0]      payload_byte,
	output logic                  frame_done,
	output logic                  frame_good,
	output logic [ByteW-1:0]      frame_ident,
	output logic [ByteW-1:0]      frame_length
);

	logic             out_free;
	logic             valid_s1;
	logic [ByteW-1:0] rx_byte_s1;
	logic             fire;
	result_t          res;
	logic             res_valid_q;
	result_t          res_q;

	assign out_free = !res_valid_q || !result_stall;

	// input register
	sfr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.rx_byte    (rx_byte),
		.out_free   (out_free),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1),
		.fire       (fire)
	);

	// parser
	sfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte_s1 (rx_byte_s1),
		.res        (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign result_valid  = res_valid_q;
	assign payload_valid = res_q.payload_valid;
	assign payload_index = res_q.payload_index;
	assign payload_byte  = res_q.payload_byte;
	assign frame_done    = res_q.frame_done;
	assign frame_good    = res_q.frame_good;
	assign frame_ident   = res_q.frame_ident;
	assign frame_length  = res_q.frame_length;

endmodule : serial_frame_receiver_sum8_core
`default_nettype wire

// ----- sim/serial_frame_receiver_sum8_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_sum8_core_tb
// Drives received bytes into the frame receiver and checks every result word
// against a cycle-free model of the parser (identifier, length, payload and
// additive checksum). A short directed run covers the edge cases, then random
// frames with bad checksums, stray bytes, one maximum-length frame, random
// idling on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module serial_frame_receiver_sum8_core_tb;
	import sfr_pkg::*;

	localparam int unsigned ByteTarget = 1500;
	localparam int unsigned HoldCycles = 80;
	localparam int unsigned StuckLimit = 4000;
	localparam int unsigned DrainCycles = 8;

	// frame parser model and queue of expected result words
	class frame_scoreboard;
		phase_t           phase;
		logic [ByteW-1:0] ident;
		logic [ByteW-1:0] len;
		logic [ByteW-1:0] pos;
		logic [ByteW-1:0] sum;
		result_t          due_q[$];
		int unsigned      fails;

		function new();
			phase = PH_IDENT;
			ident = '0;
			len   = '0;
			pos   = '0;
			sum   = '0;
			fails = 0;
		endfunction

		// advance the parse state by one taken word and queue its result
		function void note_byte(logic [ByteW-1:0] b);
			result_t r;
			r = '0;
			case (phase)
			PH_IDENT: begin
				ident = b;
				sum   = b;
				phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				len = b;
				sum = sum + b;
				pos = '0;
				if (b == '0)
					phase = PH_CHECK;
				else
					phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_index = pos;
				r.payload_byte  = b;
				sum = sum + b;
				pos = pos + 1'b1;
				if (pos == len)
					phase = PH_CHECK;
			end
			default: begin
				r.frame_done = 1'b1;
				r.frame_good = (sum == b);
				phase = PH_IDENT;
			end
			endcase
			r.frame_ident  = ident;
			r.frame_length = len;
			due_q.push_back(r);
		endfunction

		function void field_check(string name, logic [ByteW-1:0] want,
				logic [ByteW-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		// compare one delivered word with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (due_q.size() == 0) begin
				$error("result word arrived with nothing expected");
				fails++;
				return;
			end
			want = due_q.pop_front();
			field_check("payload_valid", ByteW'(want.payload_valid),
				ByteW'(got.payload_valid));
			field_check("payload_index", want.payload_index, got.payload_index);
			field_check("payload_byte", want.payload_byte, got.payload_byte);
			field_check("frame_done", ByteW'(want.frame_done), ByteW'(got.frame_done));
			field_check("frame_good", ByteW'(want.frame_good), ByteW'(got.frame_good));
			field_check("frame_ident", want.frame_ident, got.frame_ident);
			field_check("frame_length", want.frame_length, got.frame_length);
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             byte_valid;
	logic             byte_stall;
	logic [ByteW-1:0] rx_byte;
	logic             result_valid;
	logic             result_stall;
	logic             payload_valid;
	logic [ByteW-1:0] payload_index;
	logic [ByteW-1:0] payload_byte;
	logic             frame_done;
	logic             frame_good;
	logic [ByteW-1:0] frame_ident;
	logic [ByteW-1:0] frame_length;

	frame_scoreboard sb;
	int unsigned     sent;
	int unsigned     idle_pct;
	int unsigned     stall_pct;
	int unsigned     hold_token;
	int unsigned     hold_seen;
	int unsigned     hold_left;
	int unsigned     stuck_cycles;

	serial_frame_receiver_sum8_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.rx_byte       (rx_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.payload_valid (payload_valid),
		.payload_index (payload_index),
		.payload_byte  (payload_byte),
		.frame_done    (frame_done),
		.frame_good    (frame_good),
		.frame_ident   (frame_ident),
		.frame_length  (frame_length)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// offer one word, with random idle cycles first, and wait until taken
	task automatic send_byte(input logic [ByteW-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		rx_byte    <= b;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(b);
		sent++;
	endtask

	// whole frame; first payload byte given, the rest random
	task automatic send_frame(input logic [ByteW-1:0] ident, input logic [ByteW-1:0] len,
			input logic [ByteW-1:0] first, input bit corrupt);
		logic [ByteW-1:0] csum;
		logic [ByteW-1:0] pb;
		csum = ident + len;
		send_byte(ident);
		send_byte(len);
		for (int i = 0; i < len; i++) begin
			pb = (i == 0) ? first : ByteW'($urandom_range(255));
			csum = csum + pb;
			send_byte(pb);
		end
		if (corrupt)
			csum = csum ^ ByteW'($urandom_range(255, 1));
		send_byte(csum);
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		result_stall = 1'b0;
		hold_seen    = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HoldCycles - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result_t'({payload_valid, payload_index, payload_byte,
				frame_done, frame_good, frame_ident, frame_length}));
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= StuckLimit) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// stimulus
	initial begin
		logic [ByteW-1:0] flen;
		bit               big_done;
		sb           = new();
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		rx_byte      = '0;
		sent         = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_token   = 0;
		big_done     = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero length, all-ones wrap, bad checksums, short payload
		send_frame(8'h00, 8'h00, 8'h00, 1'b0);
		send_frame(8'hff, 8'h01, 8'hff, 1'b0);
		send_frame(8'h5a, 8'h02, 8'h00, 1'b1);
		send_frame(8'ha5, 8'h00, 8'h00, 1'b1);
		send_frame(8'h3c, 8'h04, 8'h80, 1'b0);

		// random frames, stray bytes and one maximum-length frame
		idle_pct  = 7;
		stall_pct = 7;
		while (sent < ByteTarget) begin
			if (sent >= 500 && sent < 900) begin
				if (idle_pct != 0) begin
					// quiet stretch, with the result side held off at its start
					idle_pct  = 0;
					stall_pct = 0;
					hold_token++;
				end
			end else begin
				idle_pct  = 7;
				stall_pct = 7;
			end
			if ($urandom_range(99) < 5) begin
				send_byte(ByteW'($urandom_range(255)));
			end else begin
				if (!big_done && sent > 100) begin
					flen     = 8'hff;
					big_done = 1'b1;
				end else if ($urandom_range(99) < 2) begin
					flen = ByteW'($urandom_range(255, 9));
				end else begin
					flen = ByteW'($urandom_range(8));
				end
				send_frame(ByteW'($urandom_range(255)), flen, ByteW'($urandom_range(255)),
					$urandom_range(99) < 20);
			end
		end

		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
